/* design/qrs_pkg.sv */
// ----------------------------------------------------------------------------
// qrs_pkg: shared types and constants of the quadratic root solver
// Holds the status codes and the control word that travels along the chain.
// ----------------------------------------------------------------------------
package qrs_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_A_ZERO   = 2'd1,
        ST_NEG_DISC = 2'd2
    } status_t;

    // Control word handed from cell to cell alongside the payload.
    typedef struct packed {
        logic    valid;
        status_t status;
    } ctl_t;

    // Width of each root on the result channel.
    localparam int ROOT_WIDTH = 33;

    // Result beat: status, root_low and root_high, padded to whole bytes.
    localparam int OUT_DATA_W = ((2 + 2 * ROOT_WIDTH + 7) / 8) * 8;

endpackage

/* design/qrs_front.sv */
// ----------------------------------------------------------------------------
// qrs_front: discriminant stage
// Two register stages: the products b*b and a*c, then D = b*b - 4ac and the
// status decision.
// ----------------------------------------------------------------------------
module qrs_front #(
    parameter int W  = 16,
    parameter int DW = 33
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic signed [W-1:0]   a_in,
    input  logic signed [W-1:0]   b_in,
    input  logic signed [W-1:0]   c_in,
    output qrs_pkg::ctl_t         ctl_out,
    output logic signed [W-1:0]   a_out,
    output logic signed [W-1:0]   b_out,
    output logic [DW-1:0]         disc_out
);

    qrs_pkg::ctl_t         ctl1_reg, ctl1_next;
    logic signed [W-1:0]   a1_reg, b1_reg;
    logic signed [2*W-1:0] bb_reg, ac_reg;
    qrs_pkg::ctl_t         ctl2_reg, ctl2_next;
    logic signed [W-1:0]   a2_reg, b2_reg;
    logic [DW-1:0]         disc_reg;
    logic signed [2*W+1:0] disc_full;

    // Stage one status: a zero leading coefficient takes precedence.
    always_comb begin
        ctl1_next.valid  = in_valid;
        ctl1_next.status = (a_in == '0) ? qrs_pkg::ST_A_ZERO : qrs_pkg::ST_OK;
    end

    // Stage two: exact discriminant in a width that cannot overflow.
    assign disc_full = {{2{bb_reg[2*W-1]}}, bb_reg} - ({{2{ac_reg[2*W-1]}}, ac_reg} <<< 2);

    always_comb begin
        ctl2_next = ctl1_reg;
        if (ctl1_reg.status == qrs_pkg::ST_OK && disc_full[2*W+1]) begin
            ctl2_next.status = qrs_pkg::ST_NEG_DISC;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end else if (en) begin
            ctl1_reg <= ctl1_next;
            ctl2_reg <= ctl2_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (en) begin
            a1_reg   <= a_in;
            b1_reg   <= b_in;
            bb_reg   <= b_in * b_in;
            ac_reg   <= a_in * c_in;
            a2_reg   <= a1_reg;
            b2_reg   <= b1_reg;
            disc_reg <= disc_full[DW-1:0];
        end
    end

    assign ctl_out  = ctl2_reg;
    assign a_out    = a2_reg;
    assign b_out    = b2_reg;
    assign disc_out = disc_reg;

endmodule

/* design/qrs_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// qrs_sqrt_cell: one digit of the square root chain
// Brings down the next bit pair of the radicand and settles one root bit.
// ----------------------------------------------------------------------------
module qrs_sqrt_cell #(
    parameter int W     = 16,
    parameter int SW    = 33,
    parameter int RAD_W = 66
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  qrs_pkg::ctl_t       ctl_in,
    input  logic [RAD_W-1:0]    rad_in,
    input  logic [SW:0]         rem_in,
    input  logic [SW-1:0]       root_in,
    input  logic signed [W-1:0] a_in,
    input  logic signed [W-1:0] b_in,
    output qrs_pkg::ctl_t       ctl_out,
    output logic [RAD_W-1:0]    rad_out,
    output logic [SW:0]         rem_out,
    output logic [SW-1:0]       root_out,
    output logic signed [W-1:0] a_out,
    output logic signed [W-1:0] b_out
);

    qrs_pkg::ctl_t       ctl_reg;
    logic [RAD_W-1:0]    rad_reg;
    logic [SW:0]         rem_reg;
    logic [SW-1:0]       root_reg;
    logic signed [W-1:0] a_reg, b_reg;
    logic [SW+2:0]       rem_wide;
    logic [SW+2:0]       trial;
    logic                fits;
    logic [SW+2:0]       rem_diff;

    // Trial subtraction of (root << 2) | 1 from the extended remainder.
    assign rem_wide = {rem_in, rad_in[RAD_W-1 -: 2]};
    assign trial    = {1'b0, root_in, 2'b01};
    assign fits     = (rem_wide >= trial);
    assign rem_diff = fits ? (rem_wide - trial) : rem_wide;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg  <= {rad_in[RAD_W-3:0], 2'b00};
            rem_reg  <= rem_diff[SW:0];
            root_reg <= {root_in[SW-2:0], fits};
            a_reg    <= a_in;
            b_reg    <= b_in;
        end
    end

    assign ctl_out  = ctl_reg;
    assign rad_out  = rad_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign a_out    = a_reg;
    assign b_out    = b_reg;

endmodule

/* design/qrs_div_cell.sv */
// ----------------------------------------------------------------------------
// qrs_div_cell: one quotient bit of the twin restoring dividers
// Both numerator magnitudes are divided by the same denominator; quotient
// bits shift in where the numerator bits shift out.
// ----------------------------------------------------------------------------
module qrs_div_cell #(
    parameter int MW  = 34,
    parameter int DVW = 17
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  qrs_pkg::ctl_t    ctl_in,
    input  logic [DVW-1:0]   den_in,
    input  logic             neg_lo_in,
    input  logic             neg_hi_in,
    input  logic [MW-1:0]    num_lo_in,
    input  logic [DVW-1:0]   rem_lo_in,
    input  logic [MW-1:0]    num_hi_in,
    input  logic [DVW-1:0]   rem_hi_in,
    output qrs_pkg::ctl_t    ctl_out,
    output logic [DVW-1:0]   den_out,
    output logic             neg_lo_out,
    output logic             neg_hi_out,
    output logic [MW-1:0]    num_lo_out,
    output logic [DVW-1:0]   rem_lo_out,
    output logic [MW-1:0]    num_hi_out,
    output logic [DVW-1:0]   rem_hi_out
);

    qrs_pkg::ctl_t  ctl_reg;
    logic [DVW-1:0] den_reg;
    logic           neg_lo_reg, neg_hi_reg;
    logic [MW-1:0]  num_lo_reg, num_hi_reg;
    logic [DVW-1:0] rem_lo_reg, rem_hi_reg;
    logic [DVW:0]   lo_wide, hi_wide, lo_diff, hi_diff;
    logic           lo_fits, hi_fits;

    // Restoring step for the minus-sign root.
    assign lo_wide = {rem_lo_in, num_lo_in[MW-1]};
    assign lo_fits = (lo_wide >= {1'b0, den_in});
    assign lo_diff = lo_fits ? (lo_wide - {1'b0, den_in}) : lo_wide;

    // Restoring step for the plus-sign root.
    assign hi_wide = {rem_hi_in, num_hi_in[MW-1]};
    assign hi_fits = (hi_wide >= {1'b0, den_in});
    assign hi_diff = hi_fits ? (hi_wide - {1'b0, den_in}) : hi_wide;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg    <= den_in;
            neg_lo_reg <= neg_lo_in;
            neg_hi_reg <= neg_hi_in;
            num_lo_reg <= {num_lo_in[MW-2:0], lo_fits};
            rem_lo_reg <= lo_diff[DVW-1:0];
            num_hi_reg <= {num_hi_in[MW-2:0], hi_fits};
            rem_hi_reg <= hi_diff[DVW-1:0];
        end
    end

    assign ctl_out    = ctl_reg;
    assign den_out    = den_reg;
    assign neg_lo_out = neg_lo_reg;
    assign neg_hi_out = neg_hi_reg;
    assign num_lo_out = num_lo_reg;
    assign rem_lo_out = rem_lo_reg;
    assign num_hi_out = num_hi_reg;
    assign rem_hi_out = rem_hi_reg;

endmodule

/* design/quadratic_root_solver_core.sv */
// ----------------------------------------------------------------------------
// quadratic_root_solver_core: real roots of a*x^2 + b*x + c in fixed point
// Discriminant stage, a chain of square root cells, a numerator stage, a
// chain of divider cells and an output register.
//
//   Channel   Direction  Beat contents (lowest bits first)
//   s_axis    in         coef_a, coef_b, coef_c
//   m_axis    out        status, root_low, root_high
//
// One beat is accepted per cycle while the output is not stalled.
// SW is the number of square root cells and MW the number of divider cells.
// Reset clears every valid bit along the chain; payload is not reset.
// The whole chain advances whenever the output register is empty or taken,
// so a stall at m_tready holds every stage in place.
// ----------------------------------------------------------------------------
module quadratic_root_solver_core #(
    parameter int COEF_WIDTH = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // coef_a, coef_b, coef_c from bit 0 up
    input  logic [((3*COEF_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // status, root_low, root_high from bit 0 up
    output logic [qrs_pkg::OUT_DATA_W-1:0]    m_tdata
);

    localparam int W     = COEF_WIDTH;
    localparam int DW    = 2 * W + 1;
    localparam int SW    = (DW + 1) / 2 + FRAC_BITS;
    localparam int RAD_W = 2 * SW;
    localparam int NW    = W + FRAC_BITS + 3;
    localparam int MW    = NW - 1;
    localparam int DVW   = W + 1;
    localparam int RW    = qrs_pkg::ROOT_WIDTH;
    localparam int CW    = (MW > RW) ? MW + 1 : RW + 1;
    localparam int PADW  = qrs_pkg::OUT_DATA_W - 2 - 2 * RW;

    logic en;

    // Discriminant stage.
    qrs_pkg::ctl_t       fr_ctl;
    logic signed [W-1:0] fr_a, fr_b;
    logic [DW-1:0]       fr_disc;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    qrs_front #(.W(W), .DW(DW)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .a_in     ($signed(s_tdata[W-1:0])),
        .b_in     ($signed(s_tdata[2*W-1:W])),
        .c_in     ($signed(s_tdata[3*W-1:2*W])),
        .ctl_out  (fr_ctl),
        .a_out    (fr_a),
        .b_out    (fr_b),
        .disc_out (fr_disc)
    );

    // Square root chain: one root bit per cell.
    qrs_pkg::ctl_t       sq_ctl  [0:SW];
    logic [RAD_W-1:0]    sq_rad  [0:SW];
    logic [SW:0]         sq_rem  [0:SW];
    logic [SW-1:0]       sq_root [0:SW];
    logic signed [W-1:0] sq_a    [0:SW];
    logic signed [W-1:0] sq_b    [0:SW];

    assign sq_ctl[0]  = fr_ctl;
    assign sq_rad[0]  = {{(RAD_W-DW-2*FRAC_BITS){1'b0}}, fr_disc, {(2*FRAC_BITS){1'b0}}};
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_a[0]    = fr_a;
    assign sq_b[0]    = fr_b;

    for (genvar i = 0; i < SW; i++) begin : g_sqrt
        qrs_sqrt_cell #(.W(W), .SW(SW), .RAD_W(RAD_W)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .ctl_in   (sq_ctl[i]),
            .rad_in   (sq_rad[i]),
            .rem_in   (sq_rem[i]),
            .root_in  (sq_root[i]),
            .a_in     (sq_a[i]),
            .b_in     (sq_b[i]),
            .ctl_out  (sq_ctl[i+1]),
            .rad_out  (sq_rad[i+1]),
            .rem_out  (sq_rem[i+1]),
            .root_out (sq_root[i+1]),
            .a_out    (sq_a[i+1]),
            .b_out    (sq_b[i+1])
        );
    end

    // Numerator stage: -b * 2^FRAC_BITS -/+ s, split into sign and magnitude.
    qrs_pkg::ctl_t        num_ctl_reg;
    logic [DVW-1:0]       num_den_reg;
    logic                 num_neg_lo_reg, num_neg_hi_reg;
    logic [MW-1:0]        num_lo_reg, num_hi_reg;
    logic signed [NW-1:0] b_ext, nb, s_ext, n_lo, n_hi, n_lo_abs, n_hi_abs;
    logic [W-1:0]         a_abs;

    assign b_ext    = {{(NW-W){sq_b[SW][W-1]}}, sq_b[SW]};
    assign nb       = -(b_ext <<< FRAC_BITS);
    assign s_ext    = {{(NW-SW){1'b0}}, sq_root[SW]};
    assign n_lo     = nb - s_ext;
    assign n_hi     = nb + s_ext;
    assign n_lo_abs = n_lo[NW-1] ? -n_lo : n_lo;
    assign n_hi_abs = n_hi[NW-1] ? -n_hi : n_hi;
    assign a_abs    = sq_a[SW][W-1] ? W'(-sq_a[SW]) : W'(sq_a[SW]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_ctl_reg <= '0;
        end else if (en) begin
            num_ctl_reg <= sq_ctl[SW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_den_reg    <= {a_abs, 1'b0};
            num_neg_lo_reg <= n_lo[NW-1] ^ sq_a[SW][W-1];
            num_neg_hi_reg <= n_hi[NW-1] ^ sq_a[SW][W-1];
            num_lo_reg     <= n_lo_abs[MW-1:0];
            num_hi_reg     <= n_hi_abs[MW-1:0];
        end
    end

    // Divider chain: one quotient bit per cell for both roots.
    qrs_pkg::ctl_t  dv_ctl    [0:MW];
    logic [DVW-1:0] dv_den    [0:MW];
    logic           dv_neg_lo [0:MW];
    logic           dv_neg_hi [0:MW];
    logic [MW-1:0]  dv_num_lo [0:MW];
    logic [DVW-1:0] dv_rem_lo [0:MW];
    logic [MW-1:0]  dv_num_hi [0:MW];
    logic [DVW-1:0] dv_rem_hi [0:MW];

    assign dv_ctl[0]    = num_ctl_reg;
    assign dv_den[0]    = num_den_reg;
    assign dv_neg_lo[0] = num_neg_lo_reg;
    assign dv_neg_hi[0] = num_neg_hi_reg;
    assign dv_num_lo[0] = num_lo_reg;
    assign dv_rem_lo[0] = '0;
    assign dv_num_hi[0] = num_hi_reg;
    assign dv_rem_hi[0] = '0;

    for (genvar j = 0; j < MW; j++) begin : g_div
        qrs_div_cell #(.MW(MW), .DVW(DVW)) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .en         (en),
            .ctl_in     (dv_ctl[j]),
            .den_in     (dv_den[j]),
            .neg_lo_in  (dv_neg_lo[j]),
            .neg_hi_in  (dv_neg_hi[j]),
            .num_lo_in  (dv_num_lo[j]),
            .rem_lo_in  (dv_rem_lo[j]),
            .num_hi_in  (dv_num_hi[j]),
            .rem_hi_in  (dv_rem_hi[j]),
            .ctl_out    (dv_ctl[j+1]),
            .den_out    (dv_den[j+1]),
            .neg_lo_out (dv_neg_lo[j+1]),
            .neg_hi_out (dv_neg_hi[j+1]),
            .num_lo_out (dv_num_lo[j+1]),
            .rem_lo_out (dv_rem_lo[j+1]),
            .num_hi_out (dv_num_hi[j+1]),
            .rem_hi_out (dv_rem_hi[j+1])
        );
    end

    // Sign restore and saturation to the root width.
    function automatic logic [RW-1:0] pack_root(input logic [MW-1:0] mag, input logic neg);
        logic [CW-1:0] q;
        logic [CW-1:0] pos_max;
        logic [CW-1:0] neg_max;
        logic [RW-1:0] r;
        q       = {{(CW-MW){1'b0}}, mag};
        pos_max = {{(CW-RW+1){1'b0}}, {(RW-1){1'b1}}};
        neg_max = pos_max + CW'(1);
        if (neg) begin
            r = (q > neg_max) ? {1'b1, {(RW-1){1'b0}}} : -q[RW-1:0];
        end else begin
            r = (q > pos_max) ? {1'b0, {(RW-1){1'b1}}} : q[RW-1:0];
        end
        return r;
    endfunction

    // Output register.
    logic                  out_valid_reg;
    qrs_pkg::status_t      out_status_reg;
    logic [RW-1:0]         out_lo_reg, out_hi_reg;
    qrs_pkg::ctl_t         last_ctl;

    assign last_ctl = dv_ctl[MW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= last_ctl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_status_reg <= last_ctl.status;
            if (last_ctl.status == qrs_pkg::ST_OK) begin
                out_lo_reg <= pack_root(dv_num_lo[MW], dv_neg_lo[MW]);
                out_hi_reg <= pack_root(dv_num_hi[MW], dv_neg_hi[MW]);
            end else begin
                out_lo_reg <= '0;
                out_hi_reg <= '0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PADW{1'b0}}, out_hi_reg, out_lo_reg, out_status_reg};

`ifndef ASSERT_OFF
    // An error beat always carries zero roots.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_status_reg != qrs_pkg::ST_OK) |->
            (out_lo_reg == '0 && out_hi_reg == '0))
        else $error("error beat with non-zero roots");

    // A stalled output beat stays in place.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> (out_valid_reg && $stable(out_status_reg) && $stable(out_lo_reg)
                 && $stable(out_hi_reg)))
        else $error("output beat changed under stall");

    // A valid leaving the root chain reaches the numerator stage.
    a_num_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && sq_ctl[SW].valid) |=> num_ctl_reg.valid)
        else $error("beat lost between root and divider chains");
`endif

endmodule
